### rtl/krpq_pkg.sv
package krpq_pkg;

    localparam int DEPTH_DEFAULT = 512;
    localparam logic [9:0] LIMIT_RESET = 10'd256;
    localparam int CFG_AW = 1;

    localparam logic [CFG_AW-1:0] CFG_DROP_ON_OVERFLOW = 1'd0;
    localparam logic [CFG_AW-1:0] CFG_QUEUE_LIMIT = 1'd1;

    localparam logic [1:0] ACT_PUSH = 2'd0;
    localparam logic [1:0] ACT_POP = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam logic [1:0] FT_UNTYPED = 2'd0;
    localparam logic [1:0] FT_KEY = 2'd1;
    localparam logic [1:0] FT_NONKEY = 2'd2;
    localparam logic [1:0] FT_UNUSED = 2'd3;

    localparam logic [2:0] ST_QUEUED = 3'd0;
    localparam logic [2:0] ST_DROPPED = 3'd1;
    localparam logic [2:0] ST_REJECTED = 3'd2;
    localparam logic [2:0] ST_FLUSHED = 3'd3;
    localparam logic [2:0] ST_POPPED = 3'd4;
    localparam logic [2:0] ST_EMPTY = 3'd5;
    localparam logic [2:0] ST_CLEARED = 3'd6;

    // first member sits in the high bits, so stream_id lands lowest
    typedef struct packed {
        logic [23:0] payload_length;
        logic [31:0] payload_ref;
        logic [1:0]  frame_type;
        logic [63:0] decode_time;
        logic [63:0] present_time;
        logic [15:0] stream_id;
    } t_desc;

    localparam int DESC_W = $bits(t_desc);

endpackage

### rtl/krpq_store.sv
module krpq_store #(
    parameter int QUEUE_DEPTH = krpq_pkg::DEPTH_DEFAULT
) (
    input  logic                           i_clk,
    input  logic                           i_we,
    input  logic [$clog2(QUEUE_DEPTH)-1:0] i_waddr,
    input  krpq_pkg::t_desc                i_wdata,
    input  logic                           i_re,
    input  logic [$clog2(QUEUE_DEPTH)-1:0] i_raddr,
    output krpq_pkg::t_desc                o_rdata
);
    import krpq_pkg::*;

    t_desc r_mem [QUEUE_DEPTH];
    t_desc r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/keyframe_resync_packet_queue.sv
// Descriptor queue for media packets: each input item is a push, pop or clear and gives one
// result item (an unused action code gives none). One item is accepted per clock unless the output
// stalls; a result is registered in the middle stage and then waits in the output register, so the
// input keeps flowing until both the middle stage and the output register are occupied. Descriptors
// live in a single-port-write, single-port-read memory of QUEUE_DEPTH entries with a registered
// read; pointers, count, keyframe wait and flush generation sit in flops. The memory has no
// clearing pass after reset.
module keyframe_resync_packet_queue #(
    parameter int QUEUE_DEPTH = krpq_pkg::DEPTH_DEFAULT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // config write port
    input  logic                        i_cfg_we,
    input  logic [krpq_pkg::CFG_AW-1:0] i_cfg_addr,
    input  logic [9:0]                  i_cfg_wdata,
    // input items
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // stream_id, present_time, decode_time, payload_ref, payload_length
    input  logic [199:0]                s_axis_tdata,
    // action, frame_type
    input  logic [3:0]                  s_axis_tuser,
    // result items
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // occupancy, full_flag, flush_generation, out_stream_id, out_present_time,
    // out_decode_time, out_frame_type, out_payload_ref, out_payload_length, zero pad
    output logic [247:0]                m_axis_tdata,
    // status
    output logic [2:0]                  m_axis_tuser
);
    import krpq_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int LW = (CW > 10) ? CW : 10;
    localparam logic [AW-1:0] LAST_PTR = AW'(QUEUE_DEPTH - 1);
    localparam logic [LW-1:0] DEPTH_L = LW'(QUEUE_DEPTH);

    logic          r_drop;
    logic [9:0]    r_limit;
    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_count, n_count;
    logic          r_await, n_await;
    logic [31:0]   r_gen, n_gen;

    logic          r_s2_valid;
    logic [2:0]    r_s2_status;
    logic [9:0]    r_s2_occ;
    logic          r_s2_full;
    logic [31:0]   r_s2_gen;

    logic          r_out_valid;
    logic [247:0]  r_out_tdata;
    logic [2:0]    r_out_tuser;

    logic          accept;
    logic          s2_adv;
    logic [1:0]    act;
    logic [1:0]    ft;
    logic [2:0]    status;
    logic          has_result;
    logic          wr_en;
    logic          rd_en;
    logic          full_now;
    logic          full_next;
    logic [LW-1:0] eff_limit;
    t_desc         wdata;
    t_desc         rdata;
    t_desc         pop_data;

    function automatic logic [AW-1:0] advance(input logic [AW-1:0] p);
        return (p == LAST_PTR) ? '0 : p + AW'(1);
    endfunction

    assign act = s_axis_tuser[1:0];
    assign ft  = s_axis_tuser[3:2];

    assign s2_adv        = r_s2_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s2_valid || s2_adv;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign eff_limit = (LW'(r_limit) < DEPTH_L) ? LW'(r_limit) : DEPTH_L;
    assign full_now  = LW'(r_count) >= eff_limit;
    assign full_next = LW'(n_count) >= eff_limit;

    assign wdata.stream_id      = s_axis_tdata[15:0];
    assign wdata.present_time   = s_axis_tdata[79:16];
    assign wdata.decode_time    = s_axis_tdata[143:80];
    assign wdata.frame_type     = ft;
    assign wdata.payload_ref    = s_axis_tdata[175:144];
    assign wdata.payload_length = s_axis_tdata[199:176];

    always_comb begin
        n_head     = r_head;
        n_tail     = r_tail;
        n_count    = r_count;
        n_await    = r_await;
        n_gen      = r_gen;
        status     = ST_QUEUED;
        has_result = 1'b1;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        case (act)
            ACT_PUSH: begin
                if (r_await && ft != FT_UNTYPED && ft != FT_KEY) begin
                    status = ST_DROPPED;
                end else begin
                    // a keyframe or an untyped frame ends the wait before the full check
                    n_await = 1'b0;
                    if (full_now) begin
                        if (r_drop) begin
                            n_head  = '0;
                            n_tail  = '0;
                            n_count = '0;
                            n_await = 1'b1;
                            status  = ST_FLUSHED;
                        end else begin
                            status = ST_REJECTED;
                        end
                    end else begin
                        wr_en   = 1'b1;
                        n_tail  = advance(r_tail);
                        n_count = r_count + CW'(1);
                        status  = ST_QUEUED;
                    end
                end
            end
            ACT_POP: begin
                if (r_count == '0) begin
                    status = ST_EMPTY;
                end else begin
                    rd_en   = 1'b1;
                    n_head  = advance(r_head);
                    n_count = r_count - CW'(1);
                    status  = ST_POPPED;
                end
            end
            ACT_CLEAR: begin
                n_head  = '0;
                n_tail  = '0;
                n_count = '0;
                n_await = 1'b0;
                n_gen   = r_gen + 32'd1;
                status  = ST_CLEARED;
            end
            default: begin
                has_result = 1'b0;
            end
        endcase
    end

    krpq_store #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (accept && wr_en),
        .i_waddr(r_tail),
        .i_wdata(wdata),
        .i_re   (accept && rd_en),
        .i_raddr(r_head),
        .o_rdata(rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drop  <= 1'b0;
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_DROP_ON_OVERFLOW: r_drop <= i_cfg_wdata[0];
                CFG_QUEUE_LIMIT:      r_limit <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_await <= 1'b0;
            r_gen   <= '0;
        end else if (accept) begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_await <= n_await;
            r_gen   <= n_gen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (accept) begin
            r_s2_valid <= has_result;
        end else if (s2_adv) begin
            r_s2_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s2_status <= status;
            r_s2_occ    <= 10'(n_count);
            r_s2_full   <= full_next;
            r_s2_gen    <= n_gen;
        end
    end

    // memory read data lines up with the middle stage
    assign pop_data = (r_s2_status == ST_POPPED) ? rdata : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_adv) begin
            r_out_tdata <= {3'b000, pop_data, r_s2_gen, r_s2_full, r_s2_occ};
            r_out_tuser <= r_s2_status;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_tdata;
    assign m_axis_tuser  = r_out_tuser;

endmodule

### rtl/krpq_checker.sv
module krpq_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [247:0] m_axis_tdata,
    input logic [2:0]   m_axis_tuser
);
    import krpq_pkg::*;

    // entry fields are zero unless an entry was popped
    a_zero_unless_popped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != ST_POPPED |-> m_axis_tdata[247:43] == '0)
        else $error("entry fields set on a non-pop result");

    // results that leave the queue empty report zero occupancy
    a_empty_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_EMPTY || m_axis_tuser == ST_CLEARED ||
        m_axis_tuser == ST_FLUSHED) |-> m_axis_tdata[9:0] == 10'd0)
        else $error("nonzero occupancy on empty, clear or flush");

    // a queued push leaves at least one entry
    a_queued_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == ST_QUEUED |-> m_axis_tdata[9:0] != 10'd0)
        else $error("queued push reports empty queue");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
        $stable(m_axis_tuser))
        else $error("stalled result changed");

endmodule

bind keyframe_resync_packet_queue krpq_checker u_krpq_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
);
